/* hw/rtl/cbr_pkg.sv */
package cbr_pkg;

	// Field and register widths
	localparam int COORD_W    = 16;
	localparam int CNT_W      = 7;
	localparam int IDX_W      = 6;
	localparam int NUM_REGS   = 8;
	localparam int REG_IDX_W  = 4;
	localparam int REG_SEL_W  = $clog2(NUM_REGS);

	// Curve parameter t is unsigned Q0.16, u = 1 - t needs one more bit
	localparam int T_W        = 16;
	localparam int U_W        = T_W + 1;
	localparam int STEP_W     = T_W + 1;

	// Shared multiplier: 34 x 18 signed, 52-bit product
	localparam int MA_W       = 34;
	localparam int MB_W       = 18;
	localparam int PROD_W     = MA_W + MB_W;

	// Weights are Q0.32 and may reach 1.0, hence 33 bits
	localparam int WT_W       = 33;
	localparam int RND_SHIFT  = 16;
	localparam int RND_W      = WT_W + RND_SHIFT;

	// Blend accumulator: |sum| < 2^49, plus rounding headroom
	localparam int ACC_W      = 51;
	localparam int OUT_SHIFT  = 32;

	localparam int DIV_STEPS  = STEP_W;
	localparam int CALC_STEPS = 15;
	localparam int SEQ_W      = 5;

	localparam int DEF_MAX_POINTS = 64;

	typedef logic signed [COORD_W-1:0] coord_t;

	localparam coord_t REG_RESET [NUM_REGS] = '{
		-16'sd12288, -16'sd4096,
		-16'sd4096,   16'sd4096,
		 16'sd4096,   16'sd4096,
		 16'sd12288, -16'sd4096
	};

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV,
		OP_UU,
		OP_TT,
		OP_UUU,
		OP_TUU,
		OP_TTU,
		OP_TTT,
		OP_X0,
		OP_X1,
		OP_X2,
		OP_X3,
		OP_Y0,
		OP_Y1,
		OP_Y2,
		OP_Y3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_CALC,
		ST_EMIT
	} state_t;

	typedef struct packed {
		op_t  op;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic last_pt;
		logic out_free;
	} sts_t;

	// Multiply schedule of one point; the final step only drains the product register
	function automatic op_t calc_op(input logic [SEQ_W-1:0] seq);
		op_t op;
		case (seq)
			5'd0:    op = OP_UU;
			5'd1:    op = OP_TT;
			5'd2:    op = OP_UUU;
			5'd3:    op = OP_TUU;
			5'd4:    op = OP_TTU;
			5'd5:    op = OP_TTT;
			5'd6:    op = OP_X0;
			5'd7:    op = OP_X1;
			5'd8:    op = OP_X2;
			5'd9:    op = OP_X3;
			5'd10:   op = OP_Y0;
			5'd11:   op = OP_Y1;
			5'd12:   op = OP_Y2;
			5'd13:   op = OP_Y3;
			default: op = OP_NONE;
		endcase
		return op;
	endfunction

endpackage

/* hw/rtl/cbr_ctrl.sv */
module cbr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  cbr_pkg::sts_t  sts,
	output cbr_pkg::cmd_t  cmd
);

	cbr_pkg::state_t state_q, state_d;
	logic [cbr_pkg::SEQ_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbr_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd.op   = cbr_pkg::OP_NONE;
		cmd.emit = 1'b0;
		in_stall = 1'b1;
		case (state_q)
			cbr_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				// a zero count is taken and dropped
				if (in_valid && !sts.cnt_zero) begin
					cmd.op  = cbr_pkg::OP_LOAD;
					state_d = cbr_pkg::ST_DIV;
					cnt_d   = '0;
				end
			end
			cbr_pkg::ST_DIV: begin
				cmd.op = cbr_pkg::OP_DIV;
				if (cnt_q == cbr_pkg::SEQ_W'(cbr_pkg::DIV_STEPS - 1)) begin
					state_d = cbr_pkg::ST_CALC;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + cbr_pkg::SEQ_W'(1);
				end
			end
			cbr_pkg::ST_CALC: begin
				cmd.op = cbr_pkg::calc_op(cnt_q);
				if (cnt_q == cbr_pkg::SEQ_W'(cbr_pkg::CALC_STEPS - 1)) begin
					state_d = cbr_pkg::ST_EMIT;
				end else begin
					cnt_d = cnt_q + cbr_pkg::SEQ_W'(1);
				end
			end
			cbr_pkg::ST_EMIT: begin
				// hold the point until the output register frees up
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cnt_d    = '0;
					state_d  = sts.last_pt ? cbr_pkg::ST_IDLE : cbr_pkg::ST_CALC;
				end
			end
			default: begin
				state_d = cbr_pkg::ST_IDLE;
			end
		endcase
	end

	a_load_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == cbr_pkg::OP_LOAD |=> state_q == cbr_pkg::ST_DIV)
		else $error("load not followed by division");

	a_calc_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cbr_pkg::ST_CALC && cnt_q == '0) |->
		($past(state_q) == cbr_pkg::ST_DIV || $past(state_q) == cbr_pkg::ST_EMIT))
		else $error("point calculation entered from wrong state");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && sts.last_pt) |=> state_q == cbr_pkg::ST_IDLE)
		else $error("sequencer did not stop after last point");

endmodule

/* hw/rtl/cbr_dp.sv */
module cbr_dp #(
	parameter int MAX_POINTS = cbr_pkg::DEF_MAX_POINTS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cbr_pkg::cmd_t                     cmd,
	output cbr_pkg::sts_t                     sts,
	input  logic [cbr_pkg::CNT_W-1:0]         point_count,
	input  logic                              cfg_wr,
	input  logic [cbr_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [cbr_pkg::COORD_W-1:0]       cfg_data,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic signed [cbr_pkg::COORD_W-1:0] point_x,
	output logic signed [cbr_pkg::COORD_W-1:0] point_y,
	output logic [cbr_pkg::IDX_W-1:0]         point_index,
	output logic                              last
);

	localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam logic [cbr_pkg::CNT_W-1:0] K_MAX = cbr_pkg::CNT_W'(MAX_POINTS);
	localparam int QW = cbr_pkg::ACC_W - cbr_pkg::OUT_SHIFT;

	cbr_pkg::coord_t p_q [cbr_pkg::NUM_REGS];

	logic [cbr_pkg::CNT_W-1:0]  k_q;
	logic [cbr_pkg::CNT_W-1:0]  k_in;
	logic [IW-1:0]              idx_q;
	logic [cbr_pkg::T_W-1:0]    t_q;
	logic [cbr_pkg::U_W-1:0]    u;
	logic [cbr_pkg::STEP_W-1:0] quo_q;
	logic [cbr_pkg::CNT_W-1:0]  rem_q;
	logic [cbr_pkg::CNT_W:0]    div_r;
	logic [cbr_pkg::CNT_W:0]    div_diff;
	logic                       div_ge;

	logic [cbr_pkg::MA_W-1:0]          ma;
	logic [cbr_pkg::MB_W-1:0]          mb;
	logic signed [cbr_pkg::PROD_W-1:0] prod_s1;
	cbr_pkg::op_t                      op_s1;

	logic [cbr_pkg::WT_W-1:0]  uu_q, tt_q;
	logic [cbr_pkg::WT_W-1:0]  w0_q, w1_q, w2_q, w3_q;
	logic [cbr_pkg::RND_W-1:0] rnd_sum;
	logic [cbr_pkg::WT_W-1:0]  rnd, rnd_x3;
	logic signed [cbr_pkg::ACC_W-1:0] accx_q, accy_q, prod_ext;

	logic                       out_valid_q;
	cbr_pkg::coord_t            x_q, y_q;
	logic [cbr_pkg::IDX_W-1:0]  index_q;
	logic                       last_q;

	function automatic cbr_pkg::coord_t round_sat(input logic signed [cbr_pkg::ACC_W-1:0] acc);
		logic signed [cbr_pkg::ACC_W-1:0] b;
		logic [QW-1:0]                    q;
		cbr_pkg::coord_t                  r;
		b = acc + (cbr_pkg::ACC_W'(1) << (cbr_pkg::OUT_SHIFT - 1));
		q = b[cbr_pkg::ACC_W-1:cbr_pkg::OUT_SHIFT];
		if ((&q[QW-1:cbr_pkg::COORD_W-1]) || !(|q[QW-1:cbr_pkg::COORD_W-1])) begin
			r = q[cbr_pkg::COORD_W-1:0];
		end else if (q[QW-1]) begin
			r = {1'b1, {(cbr_pkg::COORD_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(cbr_pkg::COORD_W-1){1'b1}}};
		end
		return r;
	endfunction

	// Control point registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cbr_pkg::NUM_REGS; i++) begin
				p_q[i] <= cbr_pkg::REG_RESET[i];
			end
		end else if (cfg_wr && cfg_index < cbr_pkg::REG_IDX_W'(cbr_pkg::NUM_REGS)) begin
			p_q[cfg_index[cbr_pkg::REG_SEL_W-1:0]] <= cfg_data;
		end
	end

	assign k_in     = (point_count > K_MAX) ? K_MAX : point_count;
	assign div_r    = {rem_q, quo_q[cbr_pkg::STEP_W-1]};
	assign div_ge   = div_r >= {1'b0, k_q};
	assign div_diff = div_r - {1'b0, k_q};
	assign u        = {1'b1, {cbr_pkg::T_W{1'b0}}} - {1'b0, t_q};

	// Step = 65536 / k by restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (cmd.op == cbr_pkg::OP_LOAD) begin
			k_q   <= k_in;
			quo_q <= {1'b1, {cbr_pkg::T_W{1'b0}}};
			rem_q <= '0;
			t_q   <= '0;
			idx_q <= '0;
		end else if (cmd.op == cbr_pkg::OP_DIV) begin
			rem_q <= div_ge ? div_diff[cbr_pkg::CNT_W-1:0] : div_r[cbr_pkg::CNT_W-1:0];
			quo_q <= {quo_q[cbr_pkg::STEP_W-2:0], div_ge};
		end else if (cmd.emit) begin
			t_q   <= t_q + quo_q[cbr_pkg::T_W-1:0];
			idx_q <= idx_q + IW'(1);
		end
	end

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			cbr_pkg::OP_UU: begin
				ma = cbr_pkg::MA_W'(u);
				mb = cbr_pkg::MB_W'(u);
			end
			cbr_pkg::OP_TT: begin
				ma = cbr_pkg::MA_W'(t_q);
				mb = cbr_pkg::MB_W'(t_q);
			end
			cbr_pkg::OP_UUU: begin
				ma = cbr_pkg::MA_W'(uu_q);
				mb = cbr_pkg::MB_W'(u);
			end
			cbr_pkg::OP_TUU: begin
				ma = cbr_pkg::MA_W'(uu_q);
				mb = cbr_pkg::MB_W'(t_q);
			end
			cbr_pkg::OP_TTU: begin
				ma = cbr_pkg::MA_W'(tt_q);
				mb = cbr_pkg::MB_W'(u);
			end
			cbr_pkg::OP_TTT: begin
				ma = cbr_pkg::MA_W'(tt_q);
				mb = cbr_pkg::MB_W'(t_q);
			end
			cbr_pkg::OP_X0: begin
				ma = cbr_pkg::MA_W'(w0_q);
				mb = cbr_pkg::MB_W'(p_q[0]);
			end
			cbr_pkg::OP_X1: begin
				ma = cbr_pkg::MA_W'(w1_q);
				mb = cbr_pkg::MB_W'(p_q[2]);
			end
			cbr_pkg::OP_X2: begin
				ma = cbr_pkg::MA_W'(w2_q);
				mb = cbr_pkg::MB_W'(p_q[4]);
			end
			cbr_pkg::OP_X3: begin
				ma = cbr_pkg::MA_W'(w3_q);
				mb = cbr_pkg::MB_W'(p_q[6]);
			end
			cbr_pkg::OP_Y0: begin
				ma = cbr_pkg::MA_W'(w0_q);
				mb = cbr_pkg::MB_W'(p_q[1]);
			end
			cbr_pkg::OP_Y1: begin
				ma = cbr_pkg::MA_W'(w1_q);
				mb = cbr_pkg::MB_W'(p_q[3]);
			end
			cbr_pkg::OP_Y2: begin
				ma = cbr_pkg::MA_W'(w2_q);
				mb = cbr_pkg::MB_W'(p_q[5]);
			end
			cbr_pkg::OP_Y3: begin
				ma = cbr_pkg::MA_W'(w3_q);
				mb = cbr_pkg::MB_W'(p_q[7]);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= cbr_pkg::OP_NONE;
		end else begin
			op_s1 <= cmd.op;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= $signed(ma) * $signed(mb);
	end

	assign rnd_sum  = prod_s1[cbr_pkg::RND_W-1:0]
		+ (cbr_pkg::RND_W'(1) << (cbr_pkg::RND_SHIFT - 1));
	assign rnd      = rnd_sum[cbr_pkg::RND_W-1:cbr_pkg::RND_SHIFT];
	assign rnd_x3   = rnd + {rnd[cbr_pkg::WT_W-2:0], 1'b0};
	assign prod_ext = prod_s1[cbr_pkg::ACC_W-1:0];

	// Write back the product issued in the previous cycle
	always_ff @(posedge clk) begin
		case (op_s1)
			cbr_pkg::OP_UU:  uu_q   <= prod_s1[cbr_pkg::WT_W-1:0];
			cbr_pkg::OP_TT:  tt_q   <= prod_s1[cbr_pkg::WT_W-1:0];
			cbr_pkg::OP_UUU: w0_q   <= rnd;
			cbr_pkg::OP_TUU: w1_q   <= rnd_x3;
			cbr_pkg::OP_TTU: w2_q   <= rnd_x3;
			cbr_pkg::OP_TTT: w3_q   <= rnd;
			cbr_pkg::OP_X0:  accx_q <= prod_ext;
			cbr_pkg::OP_X1,
			cbr_pkg::OP_X2,
			cbr_pkg::OP_X3:  accx_q <= accx_q + prod_ext;
			cbr_pkg::OP_Y0:  accy_q <= prod_ext;
			cbr_pkg::OP_Y1,
			cbr_pkg::OP_Y2,
			cbr_pkg::OP_Y3:  accy_q <= accy_q + prod_ext;
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			x_q     <= round_sat(accx_q);
			y_q     <= round_sat(accy_q);
			index_q <= cbr_pkg::IDX_W'(idx_q);
			last_q  <= sts.last_pt;
		end
	end

	assign sts.cnt_zero = point_count == '0;
	assign sts.last_pt  = (cbr_pkg::CNT_W'(idx_q) + cbr_pkg::CNT_W'(1)) == k_q;
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign point_x     = x_q;
	assign point_y     = y_q;
	assign point_index = index_q;
	assign last        = last_q;

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid)
		else $error("emitted point not presented");

	a_load_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == cbr_pkg::OP_LOAD |=> (k_q != '0 && k_q <= K_MAX))
		else $error("point count out of range after load");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable({point_x, point_y, point_index, last})))
		else $error("stalled point changed");

endmodule

/* hw/rtl/cubic_bezier_rasterizer.sv */
// Cubic Bezier point generator. Each item on the input channel carries a point
// count k (0 emits nothing, above MAX_POINTS is clamped) and yields k points of the
// curve set by four control points, written through the configuration port
// (index 0..7: p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, signed Q1.14; other
// indexes are ignored). Point i sits at t = i * floor(65536/k) and is rounded and
// saturated to signed Q1.14; the final point of an item has last set. The item is
// taken, a restoring division gives the t step, and then each point is computed
// and handed to the output register once that register is free to take it.
// The point rate is set by the single shared 34x18 multiplier, which forms the six
// products behind the four Bernstein weights and the eight weighted control
// coordinates of each point one after another. A finished point waits in the
// output register while the next one is being computed; a new item is taken
// once the last point of the current one has gone to the output register.
module cubic_bezier_rasterizer #(
	parameter int MAX_POINTS = cbr_pkg::DEF_MAX_POINTS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [cbr_pkg::CNT_W-1:0]           point_count,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [cbr_pkg::COORD_W-1:0]  point_x,
	output logic signed [cbr_pkg::COORD_W-1:0]  point_y,
	output logic [cbr_pkg::IDX_W-1:0]           point_index,
	output logic                                last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cbr_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [cbr_pkg::COORD_W-1:0]         cfg_data
);

	cbr_pkg::cmd_t cmd;
	cbr_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	cbr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	cbr_dp #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.point_count (point_count),
		.cfg_wr      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_index (point_index),
		.last        (last)
	);

endmodule
